// File: design/sivf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sivf_pkg;

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int IGN_W      = 18;
    localparam int BAT_W      = 20;
    localparam int SUM_W      = 24;
    localparam int ALPHA_W    = 9;
    localparam int DIVR_W     = 4;
    localparam int N_IGN      = 4;
    localparam int IGN_IDX_W  = 2;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 96;

    localparam int DEFAULT_WINDOW_DEPTH = 10;

    // running-average divider: quotient bits retired per cycle
    localparam int DIV_BITS  = 4;
    localparam int DIV_CYC   = SUM_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_CYC);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IGNITER_ALPHA    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BATTERY_ALPHA    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IGNITER_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IGNITER_OFFSET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BATTERY_DIVIDER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BATTERY_OFFSET   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_THRESHOLD = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LEVEL      = 3'd7;

    localparam logic [ALPHA_W-1:0]  RST_IGNITER_ALPHA    = 9'd77;
    localparam logic [ALPHA_W-1:0]  RST_BATTERY_ALPHA    = 9'd51;
    localparam logic [SAMPLE_W-1:0] RST_IGNITER_GAIN     = 16'd33915;
    localparam logic [SAMPLE_W-1:0] RST_IGNITER_OFFSET   = 16'd360;
    localparam logic [DIVR_W-1:0]   RST_BATTERY_DIVIDER  = 4'd11;
    localparam logic [SAMPLE_W-1:0] RST_BATTERY_OFFSET   = 16'd1000;
    localparam logic [SAMPLE_W-1:0] RST_STABLE_THRESHOLD = 16'd1000;
    localparam logic [SAMPLE_W-1:0] RST_FLOOR_LEVEL      = 16'd1000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_IGN,
        S_SUM,
        S_DIV,
        S_BSM,
        S_BFIN,
        S_OUT
    } state_t;

    // weights above 256 act as 256
    function automatic logic [ALPHA_W-1:0] clamp_alpha(input logic [ALPHA_W-1:0] a);
        return a[ALPHA_W-1] ? {1'b1, {(ALPHA_W-1){1'b0}}} : a;
    endfunction

endpackage

`default_nettype wire

// File: design/sivf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sivf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/supply_and_igniter_voltage_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// supply and igniter voltage filter
// input stream (s_*): one transaction per converter tick, four igniter-sense
//   samples and one raw battery sample, 16 bits each in 0.1 mV units
// output stream (m_*): one transaction per input, four smoothed igniter levels
//   (18 bit signed), the smoothed and floored battery level and a stable flag
// configuration: cfg_write with cfg_index/cfg_data writes one register in a
//   cycle; write only while no transaction is in flight
// sequence: the accepted item passes igniter issue, window update, divide,
//   battery smoothing and the result load; only then is the next input taken
// throughput: one item at a time; the running-average divider (4
//   quotient bits per cycle over a 24-bit sum) and the serial pass over the
//   four igniter channels through the shared scaling multiplier set the spacing
// the igniter smoother state lives in a 4-entry ram (entries read as zero
//   until first written), the battery window in a WINDOW_DEPTH-entry ram
// reset: all smoothers, the window sum, fill count and slot pointer clear;
//   configuration returns to its defaults; no clearing pass is needed
// stall: a finished result sits in the output register; the next item is
//   taken and processed, and its result waits until the register frees

module supply_and_igniter_voltage_filter #(
    parameter int WINDOW_DEPTH = sivf_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_write,
    input  wire logic [sivf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sivf_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // igniter_one_sample, igniter_two_sample, igniter_three_sample,
    // igniter_four_sample, battery_sample
    input  wire logic [sivf_pkg::IN_DATA_W-1:0]     s_tdata,
    // output stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // igniter_one_level, igniter_two_level, igniter_three_level,
    // igniter_four_level, battery_level, battery_stable, zero pad
    output logic [sivf_pkg::OUT_DATA_W-1:0]         m_tdata
);

    import sivf_pkg::*;

    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int PROD_W = SAMPLE_W + 1 + SAMPLE_W + 1;   // 17 x 17 signed
    localparam int IMUL_W = ALPHA_W + 1 + IGN_W + 1;       // 10 x 19 signed
    localparam int BMUL_W = ALPHA_W + 1 + BAT_W + 1;       // 10 x 21 signed

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [ALPHA_W-1:0]  igniter_alpha_reg;
    logic [ALPHA_W-1:0]  battery_alpha_reg;
    logic [SAMPLE_W-1:0] igniter_gain_reg;
    logic [SAMPLE_W-1:0] igniter_offset_reg;
    logic [DIVR_W-1:0]   battery_divider_reg;
    logic [SAMPLE_W-1:0] battery_offset_reg;
    logic [SAMPLE_W-1:0] stable_threshold_reg;
    logic [SAMPLE_W-1:0] floor_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            igniter_alpha_reg    <= RST_IGNITER_ALPHA;
            battery_alpha_reg    <= RST_BATTERY_ALPHA;
            igniter_gain_reg     <= RST_IGNITER_GAIN;
            igniter_offset_reg   <= RST_IGNITER_OFFSET;
            battery_divider_reg  <= RST_BATTERY_DIVIDER;
            battery_offset_reg   <= RST_BATTERY_OFFSET;
            stable_threshold_reg <= RST_STABLE_THRESHOLD;
            floor_level_reg      <= RST_FLOOR_LEVEL;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IGNITER_ALPHA:    igniter_alpha_reg    <= cfg_data[ALPHA_W-1:0];
                REG_BATTERY_ALPHA:    battery_alpha_reg    <= cfg_data[ALPHA_W-1:0];
                REG_IGNITER_GAIN:     igniter_gain_reg     <= cfg_data;
                REG_IGNITER_OFFSET:   igniter_offset_reg   <= cfg_data;
                REG_BATTERY_DIVIDER:  battery_divider_reg  <= cfg_data[DIVR_W-1:0];
                REG_BATTERY_OFFSET:   battery_offset_reg   <= cfg_data;
                REG_STABLE_THRESHOLD: stable_threshold_reg <= cfg_data;
                REG_FLOOR_LEVEL:      floor_level_reg      <= cfg_data;
            endcase
        end
    end

    // effective smoothing weights, 0..256, as non-negative signed operands
    logic signed [ALPHA_W:0] ign_alpha;
    logic signed [ALPHA_W:0] bat_alpha;

    assign ign_alpha = $signed({1'b0, clamp_alpha(igniter_alpha_reg)});
    assign bat_alpha = $signed({1'b0, clamp_alpha(battery_alpha_reg)});

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;

    logic [IGN_IDX_W-1:0] issue_cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 m_tvalid_reg;

    logic in_accept;
    logic ign_issue;
    logic sum_update;
    logic div_run;
    logic bat_mul;
    logic bat_finish;
    logic out_load;

    assign in_accept = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_IGN;
                end
            end
            S_IGN:
            begin
                if (issue_cnt_reg == IGN_IDX_W'(N_IGN - 1))
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_cnt_reg == DIV_CNT_W'(DIV_CYC - 1))
                begin
                    state_next = S_BSM;
                end
            end
            S_BSM:
            begin
                state_next = S_BFIN;
            end
            S_BFIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        ign_issue  = 1'b0;
        sum_update = 1'b0;
        div_run    = 1'b0;
        bat_mul    = 1'b0;
        bat_finish = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE: s_tready   = 1'b1;
            S_IGN:  ign_issue  = 1'b1;
            S_SUM:  sum_update = 1'b1;
            S_DIV:  div_run    = 1'b1;
            S_BSM:  bat_mul    = 1'b1;
            S_BFIN: bat_finish = 1'b1;
            S_OUT:  out_load   = !m_tvalid_reg || m_tready;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_cnt_reg <= '0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ign_issue)
            begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
            end
            if (div_run)
            begin
                div_cnt_reg <= (div_cnt_reg == DIV_CNT_W'(DIV_CYC - 1)) ? '0
                                                                       : div_cnt_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // input capture
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] ign_sample_reg [N_IGN];
    logic [SAMPLE_W-1:0] bat_sample_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int i = 0; i < N_IGN; i++)
            begin
                ign_sample_reg[i] <= s_tdata[i*SAMPLE_W +: SAMPLE_W];
            end
            bat_sample_reg <= s_tdata[N_IGN*SAMPLE_W +: SAMPLE_W];
        end
    end

    // ------------------------------------------------------------------
    // igniter path: three-stage pipe, one channel issued per cycle
    //   issue: offset removal and gain multiply, smoother state read
    //   stage 1: floor by 2^15, weighted difference multiply
    //   stage 2: smoother update, state write-back
    // read and write-back of one channel never touch the same entry
    // in the same cycle, so no forwarding is needed
    // ------------------------------------------------------------------
    logic                        s1_valid_reg;
    logic [IGN_IDX_W-1:0]        s1_ch_reg;
    logic signed [PROD_W-1:0]    s1_prod_reg;
    logic                        s2_valid_reg;
    logic [IGN_IDX_W-1:0]        s2_ch_reg;
    logic signed [IGN_W-1:0]     s2_prev_reg;
    logic signed [IGN_W-1:0]     s2_scaled_reg;
    logic signed [IMUL_W-1:0]    s2_mul_reg;
    logic [N_IGN-1:0]            ign_written_reg;
    logic signed [IGN_W-1:0]     ign_level_reg [N_IGN];

    logic signed [SAMPLE_W:0]    ign_delta;
    logic signed [PROD_W-1:0]    ign_prod;
    logic [IGN_W-1:0]            ign_rdata;
    logic signed [IGN_W-1:0]     s1_prev;
    logic signed [IGN_W-1:0]     s1_scaled;
    logic signed [IGN_W:0]       s1_diff;
    logic signed [IGN_W:0]       s2_sum;
    logic signed [IGN_W-1:0]     ign_new;

    assign ign_delta = $signed({1'b0, ign_sample_reg[issue_cnt_reg]})
                     - $signed({1'b0, igniter_offset_reg});
    assign ign_prod  = ign_delta * $signed({1'b0, igniter_gain_reg});

    // arithmetic shift by 15 is the floor; the result always fits 18 bits
    assign s1_prev   = ign_written_reg[s1_ch_reg] ? $signed(ign_rdata) : '0;
    assign s1_scaled = s1_prod_reg[15 +: IGN_W];
    assign s1_diff   = $signed({s1_scaled[IGN_W-1], s1_scaled})
                     - $signed({s1_prev[IGN_W-1], s1_prev});

    // prev + floor(a * (new - prev) / 256)
    assign s2_sum  = $signed({s2_prev_reg[IGN_W-1], s2_prev_reg})
                   + $signed(s2_mul_reg[8 +: IGN_W + 1]);
    assign ign_new = (s2_prev_reg == '0) ? s2_scaled_reg : s2_sum[IGN_W-1:0];

    sivf_ram #(
        .WIDTH (IGN_W),
        .DEPTH (N_IGN)
    ) u_ign_ram (
        .clk   (clk),
        .we    (s2_valid_reg),
        .waddr (s2_ch_reg),
        .wdata (ign_new),
        .re    (ign_issue),
        .raddr (issue_cnt_reg),
        .rdata (ign_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            ign_written_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= ign_issue;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg)
            begin
                ign_written_reg[s2_ch_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ch_reg     <= issue_cnt_reg;
        s1_prod_reg   <= ign_prod;
        s2_ch_reg     <= s1_ch_reg;
        s2_prev_reg   <= s1_prev;
        s2_scaled_reg <= s1_scaled;
        s2_mul_reg    <= ign_alpha * s1_diff;
        if (s2_valid_reg)
        begin
            ign_level_reg[s2_ch_reg] <= ign_new;
        end
    end

    // ------------------------------------------------------------------
    // battery path: window ram, running sum, divide by fill count
    // ------------------------------------------------------------------
    logic [SLOT_W-1:0] write_slot_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [BAT_W-1:0]  reading_reg;
    logic [BAT_W-1:0]  win_rdata;

    assign fill_next = (fill_reg < FILL_FULL) ? fill_reg + 1'b1 : fill_reg;
    assign sum_next  = (fill_reg < FILL_FULL)
                     ? sum_reg + SUM_W'(reading_reg)
                     : sum_reg + SUM_W'(reading_reg) - SUM_W'(win_rdata);

    // the entry about to be overwritten is read at acceptance and held
    sivf_ram #(
        .WIDTH (BAT_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_win_ram (
        .clk   (clk),
        .we    (sum_update),
        .waddr (write_slot_reg),
        .wdata (reading_reg),
        .re    (in_accept),
        .raddr (write_slot_reg),
        .rdata (win_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            fill_reg       <= '0;
            sum_reg        <= '0;
        end
        else if (sum_update)
        begin
            write_slot_reg <= (write_slot_reg == SLOT_LAST) ? '0 : write_slot_reg + 1'b1;
            fill_reg       <= fill_next;
            sum_reg        <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ign_issue)
        begin
            reading_reg <= BAT_W'(BAT_W'(bat_sample_reg) * BAT_W'(battery_divider_reg))
                         + BAT_W'(battery_offset_reg);
        end
    end

    // restoring divider, DIV_BITS quotient bits per cycle; fill is never zero here
    logic [SUM_W-1:0]  quo_reg;
    logic [SUM_W-1:0]  quo_next;
    logic [FILL_W-1:0] rem_reg;
    logic [FILL_W-1:0] rem_next;

    always_comb
    begin
        logic [FILL_W:0] shifted;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            shifted  = {rem_next, quo_next[SUM_W-1]};
            quo_next = {quo_next[SUM_W-2:0], 1'b0};
            if (shifted >= {1'b0, fill_reg})
            begin
                shifted     = shifted - {1'b0, fill_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = shifted[FILL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_update)
        begin
            quo_reg <= sum_next;
            rem_reg <= '0;
        end
        else if (div_run)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // ------------------------------------------------------------------
    // battery smoothing, floor level and stability
    // ------------------------------------------------------------------
    logic [BAT_W-1:0]         bat_smoothed_reg;
    logic [BAT_W-1:0]         avg_reg;
    logic signed [BMUL_W-1:0] bat_mul_reg;
    logic [BAT_W-1:0]         level_reg;
    logic                     stable_reg;

    logic [BAT_W-1:0]         avg;
    logic signed [BAT_W:0]    bat_diff;
    logic signed [BAT_W:0]    bat_sum;
    logic [BAT_W-1:0]         bat_new;
    logic signed [BAT_W:0]    bat_delta;
    logic [BAT_W:0]           bat_mag;
    logic                     bat_stable;
    logic [BAT_W-1:0]         bat_level;

    // an average above 20 bits saturates
    assign avg      = (quo_reg[SUM_W-1:BAT_W] != '0) ? '1 : quo_reg[BAT_W-1:0];
    assign bat_diff = $signed({1'b0, avg}) - $signed({1'b0, bat_smoothed_reg});

    assign bat_sum   = $signed({1'b0, bat_smoothed_reg}) + bat_mul_reg[8 +: BAT_W + 1];
    assign bat_new   = (bat_smoothed_reg == '0) ? avg_reg : bat_sum[BAT_W-1:0];
    assign bat_delta = $signed({1'b0, bat_new}) - $signed({1'b0, bat_smoothed_reg});
    assign bat_mag   = bat_delta[BAT_W] ? (BAT_W + 1)'(0) - bat_delta : bat_delta;
    assign bat_stable = bat_mag < (BAT_W + 1)'(stable_threshold_reg);
    assign bat_level  = (bat_new < BAT_W'(floor_level_reg)) ? '0 : bat_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bat_smoothed_reg <= '0;
        end
        else if (bat_finish)
        begin
            bat_smoothed_reg <= bat_level;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bat_mul)
        begin
            avg_reg     <= avg;
            bat_mul_reg <= bat_alpha * bat_diff;
        end
        if (bat_finish)
        begin
            level_reg  <= bat_level;
            stable_reg <= bat_stable;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_DATA_W-1:0] m_tdata_next;

    always_comb
    begin
        m_tdata_next = '0;
        for (int i = 0; i < N_IGN; i++)
        begin
            m_tdata_next[i*IGN_W +: IGN_W] = ign_level_reg[i];
        end
        m_tdata_next[N_IGN*IGN_W +: BAT_W] = level_reg;
        m_tdata_next[N_IGN*IGN_W + BAT_W]  = stable_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // one item at a time: no acceptance right after an acceptance
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // the igniter pipe has drained before its levels are packed
    a_ign_drained: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("igniter pipe busy at result load");

    // divisor is a filled count, never zero while dividing
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_run |-> (fill_reg != '0) && (fill_reg <= FILL_FULL))
        else $error("running average divisor out of range");

    // the window pointer stays inside the ram
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        sum_update |=> (write_slot_reg <= SLOT_LAST))
        else $error("window slot out of range");

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sivf_pkg::*;

    localparam int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH;
    // far above the slowest legal run (about 2000 ticks)
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASES       = 12;
    localparam int PHASE_TICKS  = 150;
    localparam int FINAL_TICKS  = 130;
    localparam int LONG_HOLD    = 400;

    localparam longint BAT_MAX = (longint'(1) << BAT_W) - 1;
    localparam longint SUM_MAX = (longint'(1) << SUM_W) - 1;
    localparam longint IGN_HI  = (longint'(1) << (IGN_W - 1)) - 1;
    localparam longint IGN_LO  = -(longint'(1) << (IGN_W - 1));

    // one converter tick; packs straight onto s_tdata, channel one in the lowest bits
    typedef struct packed {
        logic [SAMPLE_W-1:0]            battery;
        logic [N_IGN-1:0][SAMPLE_W-1:0] igniter;
    } tick_t;

    // one filtered result; packs onto the low bits of m_tdata
    typedef struct packed {
        logic                        battery_stable;
        logic [BAT_W-1:0]            battery_level;
        logic [N_IGN-1:0][IGN_W-1:0] igniter_level;
    } levels_t;

    typedef struct {
        logic [CFG_DATA_W-1:0] igniter_alpha;
        logic [CFG_DATA_W-1:0] battery_alpha;
        logic [CFG_DATA_W-1:0] igniter_gain;
        logic [CFG_DATA_W-1:0] igniter_offset;
        logic [CFG_DATA_W-1:0] battery_divider;
        logic [CFG_DATA_W-1:0] battery_offset;
        logic [CFG_DATA_W-1:0] stable_threshold;
        logic [CFG_DATA_W-1:0] floor_level;
    } settings_t;

    // tracks the filter state, works out the levels each tick should give,
    // and compares them against what comes out
    class level_tracker;
        logic [ALPHA_W-1:0]  igniter_alpha;
        logic [ALPHA_W-1:0]  battery_alpha;
        logic [SAMPLE_W-1:0] igniter_gain;
        logic [SAMPLE_W-1:0] igniter_offset;
        logic [DIVR_W-1:0]   battery_divider;
        logic [SAMPLE_W-1:0] battery_offset;
        logic [SAMPLE_W-1:0] stable_threshold;
        logic [SAMPLE_W-1:0] floor_level;

        longint  igniter_state[N_IGN];
        longint  window[WINDOW_DEPTH];
        int      slot;
        int      filled;
        longint  window_sum;
        longint  battery_state;
        levels_t expected_levels[$];
        string   igniter_field[N_IGN];
        int      mismatches;
        int      checked;

        function new();
            igniter_alpha    = RST_IGNITER_ALPHA;
            battery_alpha    = RST_BATTERY_ALPHA;
            igniter_gain     = RST_IGNITER_GAIN;
            igniter_offset   = RST_IGNITER_OFFSET;
            battery_divider  = RST_BATTERY_DIVIDER;
            battery_offset   = RST_BATTERY_OFFSET;
            stable_threshold = RST_STABLE_THRESHOLD;
            floor_level      = RST_FLOOR_LEVEL;
            foreach (igniter_state[i]) igniter_state[i] = 0;
            foreach (window[i]) window[i] = 0;
            slot          = 0;
            filled        = 0;
            window_sum    = 0;
            battery_state = 0;
            mismatches    = 0;
            checked       = 0;
            igniter_field = '{"igniter_one_level", "igniter_two_level",
                              "igniter_three_level", "igniter_four_level"};
        endfunction

        // register fields keep only their own width of the write data
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_IGNITER_ALPHA:    igniter_alpha    = val[ALPHA_W-1:0];
                REG_BATTERY_ALPHA:    battery_alpha    = val[ALPHA_W-1:0];
                REG_IGNITER_GAIN:     igniter_gain     = val;
                REG_IGNITER_OFFSET:   igniter_offset   = val;
                REG_BATTERY_DIVIDER:  battery_divider  = val[DIVR_W-1:0];
                REG_BATTERY_OFFSET:   battery_offset   = val;
                REG_STABLE_THRESHOLD: stable_threshold = val;
                REG_FLOOR_LEVEL:      floor_level      = val;
                default: ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        // exponential smoothing: a smoother sitting at exactly zero jumps to
        // the new value, weights above 256 act as 256, weight zero holds
        function longint blend(longint fresh, longint prev, logic [ALPHA_W-1:0] alpha);
            longint w;
            w = (alpha > 256) ? 256 : longint'(alpha);
            if (prev == 0) return fresh;
            return (w * fresh + (256 - w) * prev) >>> 8;
        endfunction

        function void note_tick(tick_t t);
            levels_t e;
            int      ch;
            longint  diff;
            longint  scaled;
            longint  reading;
            longint  avg;
            longint  smoothed;
            longint  change;
            for (ch = 0; ch < N_IGN; ch++) begin
                // offset removal, then Q1.15 gain with floor rounding
                diff   = longint'(t.igniter[ch]) - longint'(igniter_offset);
                scaled = clip((diff * longint'(igniter_gain)) >>> 15, IGN_LO, IGN_HI);
                igniter_state[ch] = clip(blend(scaled, igniter_state[ch], igniter_alpha),
                                         IGN_LO, IGN_HI);
                e.igniter_level[ch] = igniter_state[ch][IGN_W-1:0];
            end

            reading = (longint'(t.battery) * longint'(battery_divider)
                       + longint'(battery_offset)) & BAT_MAX;
            // running sum over the window; until full, average over the filled part
            if (filled < WINDOW_DEPTH) begin
                window_sum = (window_sum + reading) & SUM_MAX;
                filled++;
            end
            else begin
                window_sum = (window_sum + reading - window[slot]) & SUM_MAX;
            end
            window[slot] = reading;
            slot = (slot + 1) % WINDOW_DEPTH;

            avg      = clip(window_sum / filled, 0, BAT_MAX);
            smoothed = clip(blend(avg, battery_state, battery_alpha), 0, BAT_MAX);
            // stability looks at the change before the floor is applied
            change = smoothed - battery_state;
            if (change < 0) change = -change;
            e.battery_stable = (change < longint'(stable_threshold));
            battery_state = (smoothed < longint'(floor_level)) ? 0 : smoothed;
            e.battery_level = battery_state[BAT_W-1:0];
            expected_levels.push_back(e);
        endfunction

        function void flag(string field, longint want, longint have);
            $error("%s: expected %0d, actual %0d", field, want, have);
            mismatches++;
        endfunction

        function void check_levels(levels_t got);
            levels_t e;
            int      ch;
            if (expected_levels.size() == 0) begin
                $error("result transaction with no tick outstanding");
                mismatches++;
                return;
            end
            e = expected_levels.pop_front();
            checked++;
            for (ch = 0; ch < N_IGN; ch++)
                if (got.igniter_level[ch] !== e.igniter_level[ch])
                    flag(igniter_field[ch], longint'($signed(e.igniter_level[ch])),
                         longint'($signed(got.igniter_level[ch])));
            if (got.battery_level !== e.battery_level)
                flag("battery_level", longint'(e.battery_level), longint'(got.battery_level));
            if (got.battery_stable !== e.battery_stable)
                flag("battery_stable", longint'(e.battery_stable),
                     longint'(got.battery_stable));
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // igniter_one_sample, igniter_two_sample, igniter_three_sample,
    // igniter_four_sample, battery_sample
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // igniter_one_level .. igniter_four_level, battery_level, battery_stable, zero pad
    logic [OUT_DATA_W-1:0] m_tdata;

    level_tracker tracker = new();

    // knobs shared between the stimulus and the ready driver
    bit rx_stalls_on = 1'b1;
    bit tx_gaps_on   = 1'b1;
    int hold_cycles  = 0;
    int cycles       = 0;
    int ticks_sent   = 0;
    int settings_used = 1;

    // battery random walk, so the window and smoother see slow drifts too
    int battery_walk = 0;
    int walk_step    = 0;

    supply_and_igniter_voltage_filter #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // both handshakes are sampled at the edge, before any nonblocking update
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                tracker.note_tick(tick_t'(s_tdata));
            if (m_tvalid && m_tready)
                tracker.check_levels(levels_t'(m_tdata[$bits(levels_t)-1:0]));
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycles, tracker.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // output side: random bursts of ready and of stall, plus one long
    // hold-off on request so the block backs up and stalls its input
    initial
    begin : ready_driver
        int span;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_cycles != 0)
            begin
                span = hold_cycles;
                hold_cycles = 0;
                m_tready <= 1'b0;
            end
            else if (!rx_stalls_on || $urandom_range(0, 2) != 0)
            begin
                span = $urandom_range(1, 15);
                m_tready <= 1'b1;
            end
            else
            begin
                span = $urandom_range(1, 15);
                m_tready <= 1'b0;
            end
            repeat (span) @(posedge clk);
        end
    end

    // offer one tick and return at the edge where it is taken
    task automatic send_tick(input tick_t t);
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        ticks_sent++;
    endtask

    task automatic pause_sender(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        tracker.write_reg(idx, val);
    endtask

    task automatic apply_settings(input settings_t s);
        write_reg(REG_IGNITER_ALPHA,    s.igniter_alpha);
        write_reg(REG_BATTERY_ALPHA,    s.battery_alpha);
        write_reg(REG_IGNITER_GAIN,     s.igniter_gain);
        write_reg(REG_IGNITER_OFFSET,   s.igniter_offset);
        write_reg(REG_BATTERY_DIVIDER,  s.battery_divider);
        write_reg(REG_BATTERY_OFFSET,   s.battery_offset);
        write_reg(REG_STABLE_THRESHOLD, s.stable_threshold);
        write_reg(REG_FLOOR_LEVEL,      s.floor_level);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    function automatic tick_t mk_tick(input int one, input int two, input int three,
                                      input int four, input int bat);
        tick_t t;
        t.igniter[0] = one[SAMPLE_W-1:0];
        t.igniter[1] = two[SAMPLE_W-1:0];
        t.igniter[2] = three[SAMPLE_W-1:0];
        t.igniter[3] = four[SAMPLE_W-1:0];
        t.battery    = bat[SAMPLE_W-1:0];
        return t;
    endfunction

    function automatic int clamp_sample(input int v);
        if (v < 0) return 0;
        if (v > 65535) return 65535;
        return v;
    endfunction

    // mostly drifting battery with igniters near their zero point, some
    // fully random ticks and some rail-to-rail ones
    function automatic tick_t random_tick();
        tick_t t;
        int    r;
        int    ch;
        int    v;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            t = tick_t'(IN_DATA_W'({$urandom, $urandom, $urandom}));
        end
        else if (r < 20)
        begin
            for (ch = 0; ch < N_IGN; ch++)
                t.igniter[ch] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            t.battery = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        else
        begin
            battery_walk = clamp_sample(battery_walk + int'($urandom_range(0, 2 * walk_step))
                                        - walk_step);
            // occasional step on the supply
            if ($urandom_range(0, 49) == 0)
                battery_walk = $urandom_range(0, 65535);
            t.battery = battery_walk[SAMPLE_W-1:0];
            for (ch = 0; ch < N_IGN; ch++)
            begin
                if ($urandom_range(0, 2) != 0)
                    v = clamp_sample(int'(tracker.igniter_offset)
                                     + int'($urandom_range(0, 1000)) - 500);
                else
                    v = $urandom_range(0, 65535);
                t.igniter[ch] = v[SAMPLE_W-1:0];
            end
        end
        return t;
    endfunction

    // first settings sit on the extremes, the rest are random
    function automatic settings_t phase_settings(input int phase);
        settings_t s;
        case (phase)
            // igniter weight zero, battery weight one, zero gain, zero divider, everything else at the bottom
            0: s = '{16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
            // everything at the top
            1: s = '{16'd256, 16'd256, 16'd65535, 16'd65535, 16'd15, 16'd65535,
                     16'd65535, 16'd65535};
            // weights beyond 256, smallest nonzero divider
            2: s = '{16'd511, 16'd300, 16'd32768, 16'd360, 16'd1, 16'd0, 16'd1, 16'd0};
            // battery weight zero holds its value; high floor zeroes low readings
            3: s = '{16'd1, 16'd0, 16'd40000, 16'd65535, 16'd15, 16'd65535,
                     16'd1000, 16'd65535};
            default:
            begin
                s.igniter_alpha = CFG_DATA_W'(($urandom_range(0, 3) == 0)
                                              ? $urandom_range(0, 511)
                                              : $urandom_range(1, 256));
                s.battery_alpha = CFG_DATA_W'(($urandom_range(0, 3) == 0)
                                              ? $urandom_range(0, 511)
                                              : $urandom_range(1, 256));
                s.igniter_gain    = CFG_DATA_W'($urandom_range(0, 65535));
                s.igniter_offset  = CFG_DATA_W'($urandom_range(0, 65535));
                s.battery_divider = CFG_DATA_W'($urandom_range(0, 15));
                s.battery_offset  = CFG_DATA_W'($urandom_range(0, 65535));
                s.stable_threshold = CFG_DATA_W'($urandom_range(0, 1)
                                                 ? $urandom_range(0, 2000)
                                                 : $urandom_range(0, 65535));
                s.floor_level = CFG_DATA_W'($urandom_range(0, 1)
                                            ? $urandom_range(0, 20000)
                                            : $urandom_range(0, 65535));
                // upper write-data bits must not reach the narrow registers
                if ($urandom_range(0, 4) == 0)
                    s.igniter_alpha[CFG_DATA_W-1:ALPHA_W] = (CFG_DATA_W - ALPHA_W)'($urandom);
                if ($urandom_range(0, 4) == 0)
                    s.battery_divider[CFG_DATA_W-1:DIVR_W] = (CFG_DATA_W - DIVR_W)'($urandom);
            end
        endcase
        return s;
    endfunction

    initial
    begin : stimulus
        int phase;
        int n;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed ticks under reset settings; the window fills over the first ten
        send_tick(mk_tick(0, 0, 0, 0, 0));
        send_tick(mk_tick(65535, 65535, 65535, 65535, 65535));
        // igniter exactly at its offset, then one either side of it
        send_tick(mk_tick(360, 360, 360, 360, 0));
        send_tick(mk_tick(359, 361, 0, 65535, 1));
        send_tick(mk_tick(16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h5555));
        send_tick(mk_tick(16'hAAAA, 16'h5555, 16'hFF00, 16'h00FF, 16'hAAAA));
        // steady supply so the window wraps and the stable flag settles
        for (n = 0; n < 14; n++)
            send_tick(mk_tick(1000 + n, 2000 - n, 3000, 4000, 9000 + (n % 2)));
        drain();

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            apply_settings(phase_settings(phase));
            case ($urandom_range(0, 3))
                0: walk_step = 0;
                1: walk_step = 3;
                2: walk_step = 60;
                default: walk_step = 2500;
            endcase
            battery_walk = $urandom_range(0, 65535);
            // long output hold while the sender keeps offering back to back
            if (phase == 5)
                hold_cycles = LONG_HOLD;
            for (n = 0; n < PHASE_TICKS; n++)
            begin
                if (n % 25 == 0)
                begin
                    tx_gaps_on   = ($urandom_range(0, 2) != 0);
                    rx_stalls_on = ($urandom_range(0, 2) != 0);
                end
                // the sender sits idle mid-phase until every result is back
                if (phase == 7 && n == PHASE_TICKS / 2)
                    drain();
                else if (tx_gaps_on && !(phase == 5 && n < 40) && $urandom_range(0, 2) == 0)
                    pause_sender($urandom_range(1, 15));
                send_tick(random_tick());
            end
        end

        // closing stretch at full rate with the reset settings back in place
        drain();
        apply_settings('{CFG_DATA_W'(RST_IGNITER_ALPHA), CFG_DATA_W'(RST_BATTERY_ALPHA),
                         CFG_DATA_W'(RST_IGNITER_GAIN), CFG_DATA_W'(RST_IGNITER_OFFSET),
                         CFG_DATA_W'(RST_BATTERY_DIVIDER), CFG_DATA_W'(RST_BATTERY_OFFSET),
                         CFG_DATA_W'(RST_STABLE_THRESHOLD), CFG_DATA_W'(RST_FLOOR_LEVEL)});
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        walk_step    = 20;
        for (n = 0; n < FINAL_TICKS; n++)
            send_tick(random_tick());

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("summary: %0d ticks over %0d register settings, incl. a long output hold",
                 ticks_sent, settings_used);
        $display("summary: %0d results compared, %0d mismatches, %0d left outstanding",
                 tracker.checked, tracker.mismatches, tracker.pending());
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
